// ----- hdl/lvet_pkg.sv -----
// ----------------------------------------------------------------------------
// Label value escape and trim: shared definitions
// Types, register codes, character constants and the escape helpers used by
// the block and its ring memory.
// ----------------------------------------------------------------------------
package lvet_pkg;

   typedef logic [7:0] lvet_char_type;
   typedef logic [1:0] lvet_policy_type;

   localparam int LVET_MAX_LABEL = 64;
   localparam int LVET_CSR_AW    = 3;
   localparam int LVET_CSR_DW    = 32;

   localparam logic [LVET_CSR_AW-1:0] LVET_CSR_POLICY = 3'd0;

   localparam lvet_policy_type LVET_POLICY_NONE   = 2'd0;
   localparam lvet_policy_type LVET_POLICY_WEAK   = 2'd1;
   localparam lvet_policy_type LVET_POLICY_STRONG = 2'd2;

   localparam lvet_char_type LVET_CH_NUL      = 8'h00;
   localparam lvet_char_type LVET_CH_CTRL_MAX = 8'd31;
   localparam lvet_char_type LVET_CH_DEL      = 8'd127;
   localparam lvet_char_type LVET_CH_PERCENT  = 8'h25;
   localparam lvet_char_type LVET_CH_DOT      = 8'h2e;
   localparam lvet_char_type LVET_CH_PIPE     = 8'h7c;
   localparam lvet_char_type LVET_CH_STAR     = 8'h2a;
   localparam lvet_char_type LVET_CH_QUEST    = 8'h3f;
   localparam lvet_char_type LVET_CH_DQUOTE   = 8'h22;
   localparam lvet_char_type LVET_CH_SQUOTE   = 8'h27;
   localparam lvet_char_type LVET_CH_BSLASH   = 8'h5c;
   localparam lvet_char_type LVET_CH_BTICK    = 8'h60;
   localparam lvet_char_type LVET_CH_ZERO     = 8'h30;
   localparam lvet_char_type LVET_CH_ALPHA    = 8'h57;

   // The weak policy escapes only NUL; any other nonzero code is strong.
   function automatic logic lvet_must_escape(lvet_policy_type policy, lvet_char_type c);
      logic esc;
      if (policy == LVET_POLICY_WEAK) begin
         esc = (c == LVET_CH_NUL);
      end else begin
         esc = (c <= LVET_CH_CTRL_MAX) || (c >= LVET_CH_DEL) ||
               (c == LVET_CH_PIPE) || (c == LVET_CH_STAR) || (c == LVET_CH_QUEST) ||
               (c == LVET_CH_DQUOTE) || (c == LVET_CH_SQUOTE) ||
               (c == LVET_CH_BSLASH) || (c == LVET_CH_BTICK);
      end
      return esc;
   endfunction

   function automatic lvet_char_type lvet_hex_digit(logic [3:0] nibble);
      lvet_char_type d;
      if (nibble < 4'd10) begin
         d = LVET_CH_ZERO + {4'h0, nibble};
      end else begin
         d = LVET_CH_ALPHA + {4'h0, nibble};
      end
      return d;
   endfunction

endpackage

// ----- hdl/label_value_escape_and_trim.sv -----
// The block takes one byte of a label value per word and percent-escapes it
// by the policy register; a value longer than MAX_LABEL characters is cut to
// its head, "..." and its tail. Each byte is accepted while idle; its
// characters then come one at a time, output ones held while the result side stalls,
// and no new byte is taken until the last is through. Head characters leave
// as they are made; later ones go to a ring memory with one write and one
// read port. The word with the last byte adds the ellipsis when the value
// is trimmed, then flushes up to MAX_LABEL - MAX_LABEL/2 ring characters,
// each read in ST_RDREQ and passed on from the registered data in ST_RDOUT.
// The ring holds no reset contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// Label value escape and trim
// Percent escaping of label bytes with middle truncation to MAX_LABEL.
// ----------------------------------------------------------------------------
module label_value_escape_and_trim #(
   parameter int MAX_LABEL = lvet_pkg::LVET_MAX_LABEL
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lvet_pkg::LVET_CSR_AW-1:0]   csr_paddr,
   input  logic [lvet_pkg::LVET_CSR_DW-1:0]   csr_pwdata,
   output logic [lvet_pkg::LVET_CSR_DW-1:0]   csr_prdata,
   output logic                               csr_pready,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lvet_pkg::lvet_char_type            req_value_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lvet_pkg::lvet_char_type            rsp_out_char,
   output logic                               rsp_end_of_label,
   output logic                               rsp_was_trimmed
);
   import lvet_pkg::*;

   localparam int HALF  = MAX_LABEL / 2;
   localparam int DEPTH = MAX_LABEL - HALF;
   localparam int PW    = $clog2(DEPTH);
   localparam int LW    = $clog2(MAX_LABEL + 2);
   localparam int KW    = $clog2(DEPTH + 1);
   localparam int AW    = KW + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EMIT  = 3'd1;
   localparam logic [2:0] ST_DOTS  = 3'd2;
   localparam logic [2:0] ST_RDREQ = 3'd3;
   localparam logic [2:0] ST_RDOUT = 3'd4;

   logic [2:0]      state_ff, state_in;
   lvet_policy_type policy_ff, policy_in;
   lvet_char_type   byte_ff, byte_in;
   logic            last_ff, last_in;
   logic            esc_ff, esc_in;
   logic            pass_ff, pass_in;
   logic            trim_ff, trim_in;
   logic            tail_ff, tail_in;
   logic [1:0]      idx_ff, idx_in;
   logic [LW-1:0]   len_ff, len_in;
   logic [PW-1:0]   ptr_ff, ptr_in;
   logic [KW-1:0]   cnt_ff, cnt_in;
   logic [PW-1:0]   rdaddr_ff, rdaddr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   lvet_char_type   rsp_char_ff, rsp_char_in;
   logic            rsp_end_ff, rsp_end_in;
   logic            rsp_trim_ff, rsp_trim_in;

   logic            accept;
   logic            csr_write;
   logic            out_free;
   logic            out_load;
   logic            ring_wr;
   logic            ring_rd;
   lvet_char_type   ring_q;
   lvet_char_type   cur_char;
   logic            to_ring;
   logic            emit_last;
   logic            acc_esc;
   logic [LW+1:0]   len_sum;
   logic [LW-1:0]   len_final;
   logic [AW-1:0]   start_sum;
   logic [PW-1:0]   start_addr;
   logic [PW-1:0]   ptr_next;
   logic [PW-1:0]   rdaddr_next;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == LVET_CSR_POLICY) ?
                       LVET_CSR_DW'(policy_ff) : '0;
   assign policy_in  = (csr_write && (csr_paddr == LVET_CSR_POLICY)) ?
                       csr_pwdata[1:0] : policy_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Length after this byte, saturated one above the limit.
   assign acc_esc   = (policy_ff != LVET_POLICY_NONE) &&
                      lvet_must_escape(policy_ff, req_value_byte);
   assign len_sum   = (LW+2)'(len_ff) + (acc_esc ? (LW+2)'(3) : (LW+2)'(1));
   assign len_final = (len_sum > (LW+2)'(MAX_LABEL + 1)) ?
                      LW'(MAX_LABEL + 1) : len_sum[LW-1:0];

   assign to_ring   = !pass_ff && (len_ff >= LW'(HALF));
   assign emit_last = (idx_ff == (esc_ff ? 2'd2 : 2'd0));

   always_comb begin
      case (idx_ff)
         2'd0:    cur_char = esc_ff ? LVET_CH_PERCENT : byte_ff;
         2'd1:    cur_char = lvet_hex_digit(byte_ff[7:4]);
         default: cur_char = lvet_hex_digit(byte_ff[3:0]);
      endcase
   end

   assign ptr_next    = (ptr_ff == PW'(DEPTH - 1)) ? '0 : ptr_ff + PW'(1);
   assign rdaddr_next = (rdaddr_ff == PW'(DEPTH - 1)) ? '0 : rdaddr_ff + PW'(1);

   // Oldest ring entry still to be flushed: cnt_ff entries back from the
   // write pointer as it stands after this cycle.
   assign start_sum  = AW'(ptr_in) + AW'(DEPTH) - AW'(cnt_ff);
   assign start_addr = (start_sum >= AW'(DEPTH)) ?
                       PW'(start_sum - AW'(DEPTH)) : PW'(start_sum);

   always_comb begin
      state_in    = state_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      esc_in      = esc_ff;
      pass_in     = pass_ff;
      trim_in     = trim_ff;
      tail_in     = tail_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      ptr_in      = ptr_ff;
      cnt_in      = cnt_ff;
      rdaddr_in   = rdaddr_ff;
      out_load    = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_end_in  = rsp_end_ff;
      rsp_trim_in = rsp_trim_ff;
      ring_wr     = 1'b0;
      ring_rd     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               byte_in  = req_value_byte;
               last_in  = req_last_byte;
               esc_in   = acc_esc;
               pass_in  = (policy_ff == LVET_POLICY_NONE);
               trim_in  = (policy_ff != LVET_POLICY_NONE) && req_last_byte &&
                          (len_final > LW'(MAX_LABEL));
               tail_in  = (policy_ff != LVET_POLICY_NONE) && req_last_byte &&
                          (len_final > LW'(HALF));
               cnt_in   = (len_final > LW'(MAX_LABEL)) ? KW'(HALF - 3) :
                          KW'(len_final - LW'(HALF));
               idx_in   = 2'd0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (to_ring || out_free) begin
               if (to_ring) begin
                  ring_wr = 1'b1;
                  ptr_in  = ptr_next;
               end else begin
                  out_load    = 1'b1;
                  rsp_char_in = pass_ff ? byte_ff : cur_char;
                  rsp_end_in  = emit_last && last_ff && !tail_ff;
                  rsp_trim_in = trim_ff;
               end
               if (!pass_ff && (len_ff <= LW'(MAX_LABEL))) begin
                  len_in = len_ff + LW'(1);
               end
               if (!emit_last) begin
                  idx_in = idx_ff + 2'd1;
               end else if (trim_ff) begin
                  idx_in   = 2'd0;
                  state_in = ST_DOTS;
               end else if (tail_ff) begin
                  rdaddr_in = start_addr;
                  state_in  = ST_RDREQ;
               end else begin
                  if (last_ff) begin
                     len_in = '0;
                     ptr_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DOTS: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = LVET_CH_DOT;
               rsp_end_in  = 1'b0;
               rsp_trim_in = 1'b1;
               if (idx_ff == 2'd2) begin
                  rdaddr_in = start_addr;
                  state_in  = ST_RDREQ;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         ST_RDREQ: begin
            ring_rd  = 1'b1;
            state_in = ST_RDOUT;
         end
         ST_RDOUT: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = ring_q;
               rsp_end_in  = (cnt_ff == KW'(1));
               rsp_trim_in = trim_ff;
               cnt_in      = cnt_ff - KW'(1);
               rdaddr_in   = rdaddr_next;
               if (cnt_ff == KW'(1)) begin
                  len_in   = '0;
                  ptr_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RDREQ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= LVET_POLICY_NONE;
         len_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      esc_ff    <= esc_in;
      pass_ff   <= pass_in;
      trim_ff   <= trim_in;
      tail_ff   <= tail_in;
      idx_ff    <= idx_in;
      cnt_ff    <= cnt_in;
      rdaddr_ff <= rdaddr_in;
      if (out_load) begin
         rsp_char_ff <= rsp_char_in;
         rsp_end_ff  <= rsp_end_in;
         rsp_trim_ff <= rsp_trim_in;
      end
   end

   lvet_ring #(
      .DEPTH (DEPTH),
      .AW    (PW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (ptr_ff),
      .wr_data (cur_char),
      .rd_en   (ring_rd),
      .rd_addr (rdaddr_ff),
      .rd_data (ring_q)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = rsp_char_ff;
   assign rsp_end_of_label = rsp_end_ff;
   assign rsp_was_trimmed  = rsp_trim_ff;

`ifndef SYNTH
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ptr_ff} < (PW+1)'(DEPTH))
      else $error("Ring pointer left the ring.");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(MAX_LABEL + 1))
      else $error("Escaped length passed its saturation value.");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      out_load && rsp_end_in |=> (len_ff == '0) && (ptr_ff == '0))
      else $error("Length or pointer not cleared after the final character.");

   a_ring_port: assert property (@(posedge clock) disable iff (reset)
      !(ring_wr && ring_rd))
      else $error("Ring written and read in the same cycle.");

   a_flush_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDREQ) || (state_ff == ST_RDOUT) |-> cnt_ff != '0)
      else $error("Ring flush running with nothing left to send.");
`endif

endmodule

// ----- hdl/lvet_ring.sv -----
// ----------------------------------------------------------------------------
// Label value escape and trim: tail ring memory
// Single-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module lvet_ring #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  lvet_pkg::lvet_char_type wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output lvet_pkg::lvet_char_type rd_data
);
   import lvet_pkg::*;

   lvet_char_type mem [DEPTH];
   lvet_char_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Label value escape and trim: self-checking testbench
// Label bytes go in through a valid/stall channel while the policy register
// is stepped through all four codes over the APB port. A behavioral model
// of the escaping and middle truncation predicts every output character, and
// each accepted character is checked against the oldest prediction. The request
// side idles at random and the result side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
   import lvet_pkg::*;

   localparam int HALF_LABEL    = LVET_MAX_LABEL / 2;
   localparam int TAIL_DEPTH    = LVET_MAX_LABEL - HALF_LABEL;
   localparam int RANDOM_ITEMS  = 345;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 100;

   localparam lvet_policy_type POLICY_STRONG_ALIAS = 2'd3;

   typedef struct packed {
      lvet_char_type ch;
      logic          eol;
      logic          trim;
   } label_char_type;

   typedef struct packed {
      lvet_policy_type pol;
      lvet_char_type   value;
      logic            last;
      logic            typed;
      lvet_char_type   exp_char;
      logic            exp_end;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [LVET_CSR_AW-1:0]  csr_paddr = '0;
   logic [LVET_CSR_DW-1:0]  csr_pwdata = '0;
   logic [LVET_CSR_DW-1:0]  csr_prdata;
   logic                    csr_pready;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   lvet_char_type           req_value_byte = '0;
   logic                    req_last_byte = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   lvet_char_type           rsp_out_char;
   logic                    rsp_end_of_label;
   logic                    rsp_was_trimmed;

   lvet_policy_type         cur_policy = LVET_POLICY_NONE;
   lvet_char_type           tail_mem [TAIL_DEPTH];
   int                      tail_wr_ptr = 0;
   int                      esc_count = 0;
   label_char_type          step_chars [$];
   label_char_type          expected_chars [$];
   stim_row_type            stim_table [$];
   lvet_char_type           specials [7] = '{LVET_CH_PIPE, LVET_CH_STAR, LVET_CH_QUEST,
                                             LVET_CH_DQUOTE, LVET_CH_SQUOTE,
                                             LVET_CH_BSLASH, LVET_CH_BTICK};
   int                      mismatches = 0;
   int                      burst_left = 0;
   int                      stall_left = 0;
   int                      stall_mode = 0;

   label_value_escape_and_trim dut (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value_byte   (req_value_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_end_of_label (rsp_end_of_label),
      .rsp_was_trimmed  (rsp_was_trimmed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_step(input label_char_type w);
      step_chars.insert(step_chars.size(), w);
   endfunction

   function automatic void add_expected(input label_char_type w);
      expected_chars.insert(expected_chars.size(), w);
   endfunction

   function automatic void add_row(input stim_row_type r);
      stim_table.insert(stim_table.size(), r);
   endfunction

   function automatic logic needs_escape(lvet_char_type c);
      if (cur_policy == LVET_POLICY_WEAK) begin
         return c == LVET_CH_NUL;
      end
      return c <= LVET_CH_CTRL_MAX || c >= LVET_CH_DEL || c == LVET_CH_PIPE ||
             c == LVET_CH_STAR || c == LVET_CH_QUEST || c == LVET_CH_DQUOTE ||
             c == LVET_CH_SQUOTE || c == LVET_CH_BSLASH || c == LVET_CH_BTICK;
   endfunction

   function automatic lvet_char_type hex_char(logic [3:0] nibble);
      return (nibble < 4'd10) ? "0" + nibble : "a" + (nibble - 4'd10);
   endfunction

   task automatic take_char(input lvet_char_type c);
      if (esc_count < HALF_LABEL) begin
         add_step('{c, 1'b0, 1'b0});
      end else begin
         tail_mem[tail_wr_ptr] = c;
         tail_wr_ptr = (tail_wr_ptr + 1) % TAIL_DEPTH;
      end
      if (esc_count <= LVET_MAX_LABEL) begin
         esc_count++;
      end
   endtask

   task automatic escape_and_trim_byte(input lvet_char_type b, input logic last);
      logic trimmed;
      int   flush_n;
      int   idx;
      trimmed = 1'b0;
      flush_n = 0;
      step_chars.delete();
      if (cur_policy == LVET_POLICY_NONE) begin
         add_step('{b, last, 1'b0});
      end else begin
         if (needs_escape(b)) begin
            take_char(LVET_CH_PERCENT);
            take_char(hex_char(b[7:4]));
            take_char(hex_char(b[3:0]));
         end else begin
            take_char(b);
         end
         if (last) begin
            if (esc_count > LVET_MAX_LABEL) begin
               trimmed = 1'b1;
               repeat (3) add_step('{LVET_CH_DOT, 1'b0, 1'b0});
               flush_n = HALF_LABEL - 3;
            end else if (esc_count > HALF_LABEL) begin
               flush_n = esc_count - HALF_LABEL;
            end
            idx = (tail_wr_ptr + TAIL_DEPTH - flush_n) % TAIL_DEPTH;
            repeat (flush_n) begin
               add_step('{tail_mem[idx], 1'b0, 1'b0});
               idx = (idx + 1) % TAIL_DEPTH;
            end
            foreach (step_chars[i]) step_chars[i].trim = trimmed;
            if (step_chars.size() > 0) begin
               step_chars[step_chars.size() - 1].eol = 1'b1;
            end
         end
      end
      if (last) begin
         esc_count = 0;
         tail_wr_ptr = 0;
      end
      foreach (step_chars[i]) add_expected(step_chars[i]);
   endtask

   task automatic send_item(input lvet_char_type b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      escape_and_trim_byte(b, last);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_policy(input lvet_policy_type pol);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LVET_CSR_POLICY;
      csr_pwdata <= LVET_CSR_DW'(pol);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_policy = pol;
   endtask

   function automatic int pick_length();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom_range(1, 6);
         3, 4, 5: return $urandom_range(7, 30);
         default: return $urandom_range(20, 75);
      endcase
   endfunction

   function automatic lvet_char_type random_byte();
      case ($urandom_range(0, 7))
         0, 1: return lvet_char_type'($urandom_range(32, 126));
         2: return specials[$urandom_range(0, 6)];
         3: return lvet_char_type'($urandom_range(0, 31));
         4: return lvet_char_type'($urandom_range(127, 255));
         5: return LVET_CH_NUL;
         default: return lvet_char_type'($urandom_range(0, 255));
      endcase
   endfunction

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(8, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_left[3];
      endcase
   end

   always @(posedge clock) begin
      label_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected word, char %h end %b trim %b", $time,
                     rsp_out_char, rsp_end_of_label, rsp_was_trimmed);
            mismatches++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_out_char !== want.ch) begin
               $display("%0t: out_char expected %h got %h", $time, want.ch, rsp_out_char);
               mismatches++;
            end
            if (rsp_end_of_label !== want.eol) begin
               $display("%0t: end_of_label expected %b got %b", $time, want.eol,
                        rsp_end_of_label);
               mismatches++;
            end
            if (rsp_was_trimmed !== want.trim) begin
               $display("%0t: was_trimmed expected %b got %b", $time, want.trim,
                        rsp_was_trimmed);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int              sent;
      int              phase;
      int              value_left;
      lvet_policy_type next_pol;

      add_row('{LVET_POLICY_NONE, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0});
      add_row('{LVET_POLICY_NONE, 8'hff, 1'b1, 1'b1, 8'hff, 1'b1});
      add_row('{LVET_POLICY_WEAK, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0});
      add_row('{LVET_POLICY_WEAK, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0});
      add_row('{LVET_POLICY_STRONG, LVET_CH_DEL, 1'b1, 1'b0, 8'h00, 1'b0});
      add_row('{POLICY_STRONG_ALIAS, LVET_CH_DQUOTE, 1'b1, 1'b0, 8'h00, 1'b0});
      for (int i = 0; i < 22; i++) begin
         add_row('{LVET_POLICY_STRONG, lvet_char_type'(8'h80 + i), i == 21,
                   1'b0, 8'h00, 1'b0});
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].pol != cur_policy) begin
            wait_idle();
            write_policy(stim_table[i].pol);
         end
         send_item(stim_table[i].value, stim_table[i].last);
         if (stim_table[i].typed) begin
            // Passthrough gives exactly one character; use the typed-in value.
            void'(expected_chars.pop_back());
            add_expected('{stim_table[i].exp_char, stim_table[i].exp_end, 1'b0});
         end
      end

      sent = 0;
      phase = 0;
      value_left = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0: next_pol = LVET_POLICY_NONE;
            1: next_pol = POLICY_STRONG_ALIAS;
            2: next_pol = LVET_POLICY_WEAK;
            3: next_pol = LVET_POLICY_STRONG;
            default: next_pol = lvet_policy_type'($urandom_range(0, 3));
         endcase
         phase++;
         wait_idle();
         write_policy(next_pol);
         repeat ($urandom_range(20, 70)) begin
            if (sent < RANDOM_ITEMS) begin
               if (value_left == 0) begin
                  value_left = pick_length();
               end
               value_left--;
               send_item(random_byte(), value_left == 0 || sent == RANDOM_ITEMS - 1);
               sent++;
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("%0t: timeout with %0d words outstanding", $time, expected_chars.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/lvet_pkg.sv
hdl/lvet_ring.sv
hdl/label_value_escape_and_trim.sv
bench/testbench.sv
